// ----- rtl/pfd_pkg.sv -----
// Shared constants, codes and types for the polyphase FIR decimator.
`default_nettype none
package pfd_pkg;

  localparam int MAX_TAPS  = 128;
  localparam int MAX_DECIM = 8;
  localparam int TAP_AW    = $clog2(MAX_TAPS);
  localparam int FRAC_SHIFT = 15;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 16;
  localparam int CIDX_W   = 7;
  localparam int DECIM_W  = 4;
  localparam int TAPS_W   = 8;
  localparam int PHASE_W  = 3;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 64;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOWN_RATIO = 1'b0,
    REG_TAP_COUNT  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // One operand pair for the shared MAC, plus accumulator clear.
  typedef struct packed {
    logic                       valid;
    logic                       clear;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SAMPLE_W-1:0] sample;
  } mac_op_t;

endpackage
`default_nettype wire

// ----- rtl/pfd_if.sv -----
// Valid/ready channel interfaces for the decimator input and output.
`default_nettype none
interface pfd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic signed [pfd_pkg::SAMPLE_W-1:0]  sample;
  logic        [pfd_pkg::CIDX_W-1:0]    coef_index;
  logic signed [pfd_pkg::COEF_W-1:0]    coef_value;

  modport source (output valid, operation, sample, coef_index, coef_value, input ready);
  modport sink   (input valid, operation, sample, coef_index, coef_value, output ready);
endinterface

interface pfd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pfd_pkg::SAMPLE_W-1:0]  filtered;

  modport source (output valid, filtered, input ready);
  modport sink   (input valid, filtered, output ready);
endinterface
`default_nettype wire

// ----- rtl/pfd_mac.sv -----
// Shared multiply-accumulate unit: registered product, 64-bit accumulator.
`default_nettype none
module pfd_mac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pfd_pkg::mac_op_t                    op,
  output logic                                     busy,
  output logic signed [pfd_pkg::SAMPLE_W-1:0]      acc_q15
);

  logic                                prod_v;
  logic signed [pfd_pkg::PROD_W-1:0]   prod;
  logic signed [pfd_pkg::ACC_W-1:0]    acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= op.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op.coef * op.sample;
    if (op.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + {{(pfd_pkg::ACC_W - pfd_pkg::PROD_W){prod[pfd_pkg::PROD_W-1]}}, prod};
    end
  end

  assign busy = prod_v;
  // Arithmetic shift by the fraction width, keep the low word (wraps).
  assign acc_q15 = acc[pfd_pkg::FRAC_SHIFT +: pfd_pkg::SAMPLE_W];

endmodule
`default_nettype wire

// ----- rtl/pfd_seq.sv -----
// Sequencer: delay line and coefficient memories, write pointer, phase, tap walk.
`default_nettype none
module pfd_seq (
  input  wire logic                              clk,
  input  wire logic                              rst,
  pfd_in_if.sink                                 feed,
  input  wire logic [pfd_pkg::DECIM_W-1:0]       down_ratio,
  input  wire logic [pfd_pkg::TAPS_W-1:0]        tap_count,
  input  wire logic                              mac_busy,
  input  wire logic                              out_free,
  output pfd_pkg::mac_op_t                       mac_op,
  output logic                                   emit
);

  localparam int AW = pfd_pkg::TAP_AW;

  pfd_pkg::state_t               state, state_next;
  logic [AW-1:0]                 write_pos;
  logic [pfd_pkg::PHASE_W-1:0]   phase;
  logic [pfd_pkg::TAPS_W-1:0]    k, k_next;
  logic [AW-1:0]                 rd, rd_next;
  logic                          s1_v;
  logic                          issue;
  logic                          clear;

  logic [pfd_pkg::SAMPLE_W-1:0]  dl_mem [pfd_pkg::MAX_TAPS];
  logic [pfd_pkg::COEF_W-1:0]    cf_mem [pfd_pkg::MAX_TAPS];
  logic [pfd_pkg::MAX_TAPS-1:0]  dl_valid;
  logic [pfd_pkg::MAX_TAPS-1:0]  cf_valid;
  logic [pfd_pkg::SAMPLE_W-1:0]  sample_q;
  logic [pfd_pkg::COEF_W-1:0]    coef_q;
  logic                          sample_ok;
  logic                          coef_ok;

  logic [pfd_pkg::TAPS_W-1:0]    n;
  logic [pfd_pkg::DECIM_W-1:0]   m;
  logic                          accept;
  logic                          push;
  logic                          load;
  logic [AW-1:0]                 pos_w;
  logic [pfd_pkg::TAPS_W-1:0]    pos_inc;
  logic [AW-1:0]                 pos_n;
  logic [pfd_pkg::DECIM_W-1:0]   phase_inc;
  logic                          fire;
  logic [pfd_pkg::TAPS_W-1:0]    rd_inc;

  // Clamp registers to their usable ranges.
  always_comb begin
    if (tap_count == '0) begin
      n = pfd_pkg::TAPS_W'(1);
    end else if (tap_count > pfd_pkg::TAPS_W'(pfd_pkg::MAX_TAPS)) begin
      n = pfd_pkg::TAPS_W'(pfd_pkg::MAX_TAPS);
    end else begin
      n = tap_count;
    end
    if (down_ratio == '0) begin
      m = pfd_pkg::DECIM_W'(1);
    end else if (down_ratio > pfd_pkg::DECIM_W'(pfd_pkg::MAX_DECIM)) begin
      m = pfd_pkg::DECIM_W'(pfd_pkg::MAX_DECIM);
    end else begin
      m = down_ratio;
    end
  end

  assign feed.ready = (state == pfd_pkg::ST_IDLE);
  assign accept     = feed.valid && feed.ready;
  assign push       = accept && (feed.operation == pfd_pkg::OP_PUSH);
  assign load       = accept && (feed.operation == pfd_pkg::OP_LOAD);

  // Restart at slot 0 if the line has shrunk under the pointer.
  assign pos_w     = ({1'b0, write_pos} < n) ? write_pos : '0;
  assign pos_inc   = {1'b0, pos_w} + pfd_pkg::TAPS_W'(1);
  assign pos_n     = (pos_inc < n) ? pos_inc[AW-1:0] : '0;
  assign phase_inc = {1'b0, phase} + pfd_pkg::DECIM_W'(1);
  assign fire      = !(phase_inc < m);
  assign rd_inc    = {1'b0, rd} + pfd_pkg::TAPS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfd_pkg::ST_IDLE;
      write_pos <= '0;
      phase     <= '0;
      k         <= '0;
      rd        <= '0;
      s1_v      <= 1'b0;
      dl_valid  <= '0;
      cf_valid  <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      rd    <= rd_next;
      s1_v  <= issue;
      if (push) begin
        dl_valid[pos_w] <= 1'b1;
        write_pos       <= pos_n;
        phase           <= fire ? '0 : phase_inc[pfd_pkg::PHASE_W-1:0];
      end
      if (load) begin
        cf_valid[feed.coef_index[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Memory ports: one write at accept, one registered read per tap.
  always_ff @(posedge clk) begin
    if (push) begin
      dl_mem[pos_w] <= feed.sample;
    end
    if (load) begin
      cf_mem[feed.coef_index[AW-1:0]] <= feed.coef_value;
    end
    sample_q  <= dl_mem[rd];
    coef_q    <= cf_mem[k[AW-1:0]];
    sample_ok <= dl_valid[rd];
    coef_ok   <= cf_valid[k[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    rd_next    = rd;
    issue      = 1'b0;
    clear      = 1'b0;
    emit       = 1'b0;
    case (state)
      pfd_pkg::ST_IDLE: begin
        if (push && fire) begin
          // Oldest sample sits at the slot after the one just written.
          clear      = 1'b1;
          k_next     = '0;
          rd_next    = pos_n;
          state_next = pfd_pkg::ST_RUN;
        end
      end
      pfd_pkg::ST_RUN: begin
        issue   = 1'b1;
        k_next  = k + pfd_pkg::TAPS_W'(1);
        rd_next = (rd_inc < n) ? rd_inc[AW-1:0] : '0;
        if (k == n - pfd_pkg::TAPS_W'(1)) begin
          state_next = pfd_pkg::ST_DRAIN;
        end
      end
      pfd_pkg::ST_DRAIN: begin
        // Wait for the MAC pipe to empty and the output slot to free up.
        if (!s1_v && !mac_busy && out_free) begin
          emit       = 1'b1;
          state_next = pfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mac_op.valid  = s1_v;
    mac_op.clear  = clear;
    mac_op.coef   = coef_ok ? coef_q : '0;
    mac_op.sample = sample_ok ? sample_q : '0;
  end

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == pfd_pkg::ST_RUN) |-> (k < n) && ({1'b0, rd} < n))
    else $error("tap walk left the active delay line");

  a_pipe_idle_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !s1_v && !mac_busy)
    else $error("item accepted while the MAC pipe still holds products");

  a_clear_only_on_start: assert property (@(posedge clk) disable iff (rst)
    clear |=> (state == pfd_pkg::ST_RUN) && (k == '0))
    else $error("accumulator cleared outside the start of a tap walk");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free && (state == pfd_pkg::ST_DRAIN))
    else $error("result emitted with no free output slot");

endmodule
`default_nettype wire

// ----- rtl/polyphase_fir_decimator.sv -----
// Top level: configuration registers, sequencer, shared MAC and output register.
//
//  channel   dir  handshake          payload
//  feed      in   valid/ready        operation, sample, coef_index, coef_value
//  result    out  valid/ready        filtered
//  cfg       in   cfg_we             cfg_index, cfg_wdata
//
// A coefficient load, or a push that does not end a decimation period, leaves the
// sequencer idle. A push that ends a period starts a tap walk: one MAC issue per tap,
// set by the single delay-line read port and the one shared multiplier, then the
// memory read, product and accumulate stages.
// Synchronous reset clears the pointers, phase and the valid bits of both memories;
// entries never written read as zero.
// A full output register that is not taken holds the sequencer at the end of a walk.
`default_nettype none
module polyphase_fir_decimator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  pfd_in_if.sink                                  feed,
  pfd_out_if.source                               result,
  input  wire logic                               cfg_we,
  input  wire logic [pfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [pfd_pkg::DECIM_W-1:0]          down_ratio;
  logic [pfd_pkg::TAPS_W-1:0]           tap_count;
  pfd_pkg::mac_op_t                     mac_op;
  logic                                 mac_busy;
  logic signed [pfd_pkg::SAMPLE_W-1:0]  acc_q15;
  logic                                 emit;
  logic                                 out_valid;
  logic signed [pfd_pkg::SAMPLE_W-1:0]  out_data;
  logic                                 out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_ratio <= pfd_pkg::DECIM_W'(3);
      tap_count  <= pfd_pkg::TAPS_W'(101);
    end else if (cfg_we) begin
      case (cfg_index)
        pfd_pkg::REG_DOWN_RATIO: down_ratio <= cfg_wdata[pfd_pkg::DECIM_W-1:0];
        pfd_pkg::REG_TAP_COUNT:  tap_count  <= cfg_wdata[pfd_pkg::TAPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pfd_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed),
    .down_ratio (down_ratio),
    .tap_count  (tap_count),
    .mac_busy   (mac_busy),
    .out_free   (out_free),
    .mac_op     (mac_op),
    .emit       (emit)
  );

  pfd_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .op      (mac_op),
    .busy    (mac_busy),
    .acc_q15 (acc_q15)
  );

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= acc_q15;
    end
  end

  assign result.valid    = out_valid;
  assign result.filtered = out_data;

endmodule
`default_nettype wire
